/* src/buhs_pkg.sv */
`timescale 1ns / 1ps

package buhs_pkg;

   typedef logic [63:0] word_type;
   typedef logic [1:0]  req_code_type;
   typedef logic [3:0]  peek_depth_type;
   typedef logic [4:0]  count_out_type;
   typedef logic [1:0]  status_code_type;

   localparam req_code_type REQ_PUSH    = 2'd0;
   localparam req_code_type REQ_POP     = 2'd1;
   localparam req_code_type REQ_PEEK    = 2'd2;
   localparam req_code_type REQ_UNKNOWN = 2'd3;

   localparam status_code_type STATUS_OK     = 2'd0;
   localparam status_code_type STATUS_FAIL   = 2'd1;
   localparam status_code_type STATUS_PAUSED = 2'd2;

   typedef struct packed {
      logic accept;     // request transaction taken this cycle
      logic load_read;  // capture memory read data into the result
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_read;  // current request reads the entry memory
   } dp_status_type;

endpackage

/* src/buhs_req_if.sv */
`timescale 1ns / 1ps

interface buhs_req_if;
   logic                     valid;
   logic                     ready;
   buhs_pkg::req_code_type   req_type;
   buhs_pkg::word_type       entry_data;
   buhs_pkg::peek_depth_type peek_depth;

   modport source (output valid, req_type, entry_data, peek_depth, input ready);
   modport sink   (input valid, req_type, entry_data, peek_depth, output ready);
endinterface

/* src/buhs_rsp_if.sv */
`timescale 1ns / 1ps

interface buhs_rsp_if;
   logic                      valid;
   logic                      ready;
   buhs_pkg::status_code_type status;
   buhs_pkg::word_type        read_data;
   buhs_pkg::count_out_type   entry_count;

   modport source (output valid, status, read_data, entry_count, input ready);
   modport sink   (input valid, status, read_data, entry_count, output ready);
endinterface

/* src/buhs_csr_if.sv */
`timescale 1ns / 1ps

interface buhs_csr_if;
   logic valid;
   logic ready;
   logic pause_pushes;

   modport source (output valid, pause_pushes, input ready);
   modport sink   (input valid, pause_pushes, output ready);
endinterface

/* src/buhs_ram.sv */
`timescale 1ns / 1ps

module buhs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/buhs_ctrl.sv */
`timescale 1ns / 1ps

module buhs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  buhs_pkg::dp_status_type dp_status,
   output buhs_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   assign cmd.accept    = req_valid && req_ready_ff;
   assign cmd.load_read = (state_ff == ST_READ);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  req_ready_ff <= 1'b0;
                  if (dp_status.need_read) begin
                     state_ff <= ST_READ;
                  end else begin
                     state_ff     <= ST_RESP;
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            ST_READ: begin
               state_ff     <= ST_RESP;
               rsp_valid_ff <= 1'b1;
            end
            ST_RESP: begin
               // hold the result until the sink takes it
               if (rsp_ready) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* src/buhs_datapath.sv */
`timescale 1ns / 1ps

module buhs_datapath #(
   parameter int DEPTH       = 16,
   parameter int ENTRY_WIDTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  buhs_pkg::ctrl_cmd_type     cmd,
   output buhs_pkg::dp_status_type    dp_status,
   input  buhs_pkg::req_code_type     req_type,
   input  buhs_pkg::word_type         entry_data,
   input  buhs_pkg::peek_depth_type   peek_depth,
   input  logic                       csr_write,
   input  logic                       csr_pause,
   output buhs_pkg::status_code_type  rsp_status,
   output buhs_pkg::word_type         rsp_read_data,
   output buhs_pkg::count_out_type    rsp_entry_count
);

   localparam int SLOT_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = SLOT_W + 1;
   localparam int CMP_W  = (CNT_W > 4) ? CNT_W : 4;

   logic [SLOT_W-1:0] oldest_ff, oldest_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pause_ff;

   buhs_pkg::status_code_type rsp_status_ff, status_in;
   buhs_pkg::word_type        rsp_data_ff;
   buhs_pkg::count_out_type   rsp_count_ff;

   logic                   full;
   logic                   pop_ok;
   logic                   peek_ok;
   logic [CMP_W-1:0]       peek_off_wide;
   logic [CNT_W-1:0]       peek_off;
   logic                   wr_hit;
   logic                   rd_hit;
   logic [SLOT_W-1:0]      wr_slot;
   logic [SLOT_W-1:0]      rd_slot;
   logic [ENTRY_WIDTH-1:0] ram_rd_data;

   // ring index of the entry at a given distance above the oldest one
   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] base,
                                                 input logic [CNT_W-1:0]  offset);
      logic [SUM_W-1:0] sum;
      sum = {1'b0, base} + SUM_W'(offset);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[SLOT_W-1:0];
   endfunction

   assign full          = (count_ff == CNT_W'(DEPTH));
   assign pop_ok        = (count_ff != '0);
   assign peek_ok       = (CMP_W'(peek_depth) < CMP_W'(count_ff));
   assign peek_off_wide = CMP_W'(count_ff) - CMP_W'(1) - CMP_W'(peek_depth);
   assign peek_off      = peek_off_wide[CNT_W-1:0];

   always_comb begin
      oldest_in = oldest_ff;
      count_in  = count_ff;
      status_in = buhs_pkg::STATUS_FAIL;
      wr_hit    = 1'b0;
      rd_hit    = 1'b0;
      wr_slot   = slot_of(oldest_ff, count_ff);
      rd_slot   = slot_of(oldest_ff, count_ff - CNT_W'(1));
      case (req_type)
         buhs_pkg::REQ_PUSH: begin
            if (pause_ff) begin
               status_in = buhs_pkg::STATUS_PAUSED;
            end else begin
               status_in = buhs_pkg::STATUS_OK;
               wr_hit    = 1'b1;
               if (full) begin
                  // overwrite the oldest entry and advance past it
                  wr_slot   = oldest_ff;
                  oldest_in = slot_of(oldest_ff, CNT_W'(1));
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         buhs_pkg::REQ_POP: begin
            if (pop_ok) begin
               status_in = buhs_pkg::STATUS_OK;
               rd_hit    = 1'b1;
               count_in  = count_ff - CNT_W'(1);
            end
         end
         buhs_pkg::REQ_PEEK: begin
            if (peek_ok) begin
               status_in = buhs_pkg::STATUS_OK;
               rd_hit    = 1'b1;
               rd_slot   = slot_of(oldest_ff, peek_off);
            end
         end
         default: begin
            status_in = buhs_pkg::STATUS_FAIL;
         end
      endcase
   end

   assign dp_status.need_read = rd_hit;

   buhs_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.accept && wr_hit),
      .wr_addr (wr_slot),
      .wr_data (entry_data[ENTRY_WIDTH-1:0]),
      .rd_en   (cmd.accept && rd_hit),
      .rd_addr (rd_slot),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         count_ff  <= '0;
         pause_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            pause_ff <= csr_pause;
         end
         if (cmd.accept) begin
            oldest_ff <= oldest_in;
            count_ff  <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rsp_status_ff <= status_in;
         rsp_count_ff  <= buhs_pkg::count_out_type'(count_in);
         rsp_data_ff   <= '0;
      end else if (cmd.load_read) begin
         rsp_data_ff <= buhs_pkg::word_type'(ram_rd_data);
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

/* src/bounded_undo_history_stack.sv */
`timescale 1ns / 1ps

// Bounded undo history stack: a ring of DEPTH entries of ENTRY_WIDTH bits in one
// dual-port RAM. A push that is not paused stores its entry above the newest one
// and, once the ring is full, overwrites the oldest; a pop returns and removes the
// newest; a peek returns the entry peek_depth places below the newest. One request
// is handled at a time. A push, a paused push, a failed request or an unknown code
// gives its result in the cycle after acceptance; a pop or peek that hits an entry
// passes through a read state first, for the RAM's registered read. The next
// request is accepted the cycle after the result transaction. entry_count shows
// the low five bits of the fill count. The RAM needs no clearing after reset: only
// live entries are read.
// The csr port is always ready; write it only while no request is in flight.

module bounded_undo_history_stack #(
   parameter int DEPTH       = 16,
   parameter int ENTRY_WIDTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   buhs_csr_if.sink          csr_bus,
   buhs_req_if.sink          req_bus,
   buhs_rsp_if.source        rsp_bus
);

   buhs_pkg::ctrl_cmd_type  cmd;
   buhs_pkg::dp_status_type dp_status;

   assign csr_bus.ready = 1'b1;

   buhs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   buhs_datapath #(
      .DEPTH       (DEPTH),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .dp_status       (dp_status),
      .req_type        (req_bus.req_type),
      .entry_data      (req_bus.entry_data),
      .peek_depth      (req_bus.peek_depth),
      .csr_write       (csr_bus.valid),
      .csr_pause       (csr_bus.pause_pushes),
      .rsp_status      (rsp_bus.status),
      .rsp_read_data   (rsp_bus.read_data),
      .rsp_entry_count (rsp_bus.entry_count)
   );

endmodule

/* src/buhs_checker.sv */
`timescale 1ns / 1ps

module buhs_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input buhs_pkg::req_code_type    req_type,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input buhs_pkg::status_code_type rsp_status,
   input buhs_pkg::word_type        rsp_read_data,
   input buhs_pkg::count_out_type   rsp_entry_count
);

   // one request in flight: no new transaction while a result is offered
   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while a result is pending");

   // a push never reads memory and never fails
   a_push_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == buhs_pkg::REQ_PUSH) |=>
         (rsp_valid && rsp_status != buhs_pkg::STATUS_FAIL && rsp_read_data == '0))
      else $error("push result missing or malformed");

   // an unknown request fails at once with no data
   a_unknown_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == buhs_pkg::REQ_UNKNOWN) |=>
         (rsp_valid && rsp_status == buhs_pkg::STATUS_FAIL && rsp_read_data == '0))
      else $error("unknown request result malformed");

   // exactly one result per request
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("result offered twice");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_read_data)
          && $stable(rsp_entry_count)))
      else $error("stalled result changed");

endmodule

bind bounded_undo_history_stack buhs_checker u_buhs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_type        (req_bus.req_type),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_read_data   (rsp_bus.read_data),
   .rsp_entry_count (rsp_bus.entry_count)
);
